// File: rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg: shared types and constants of the RESP2 stream parser
// Character codes, parse phase codes, event and error codes, and the
// result beat and configuration structures.
// ----------------------------------------------------------------------------
package rsp_pkg;

  // Nesting limit and derived stack sizes.
  localparam int MAX_NESTING = 32;
  localparam int DEPTH_W     = 6;
  localparam int STK_AW      = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  // Output queue geometry.
  localparam int FIFO_AW    = 2;
  localparam int FIFO_DEPTH = 1 << FIFO_AW;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BULK  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ARRAY = 1'd1;
  localparam logic [31:0] MAX_BULK_RESET  = 32'd536870912;
  localparam logic [31:0] MAX_ARRAY_RESET = 32'd1048576;

  // Characters.
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Parse phases.
  localparam logic [2:0] PH_IDLE     = 3'd0;
  localparam logic [2:0] PH_LINE     = 3'd1;
  localparam logic [2:0] PH_NUM_LEAD = 3'd2;
  localparam logic [2:0] PH_NUM_BODY = 3'd3;
  localparam logic [2:0] PH_NUM_JUNK = 3'd4;
  localparam logic [2:0] PH_BULK     = 3'd5;
  localparam logic [2:0] PH_BULK_CR  = 3'd6;
  localparam logic [2:0] PH_BULK_LF  = 3'd7;

  // Event kinds.
  localparam logic [1:0] EV_PAYLOAD = 2'd0;
  localparam logic [1:0] EV_HEADER  = 2'd1;
  localparam logic [1:0] EV_END     = 2'd2;
  localparam logic [1:0] EV_ERROR   = 2'd3;

  // Element types.
  localparam logic [2:0] TY_SIMPLE = 3'd0;
  localparam logic [2:0] TY_ERROR  = 3'd1;
  localparam logic [2:0] TY_INT    = 3'd2;
  localparam logic [2:0] TY_BULK   = 3'd3;
  localparam logic [2:0] TY_ARRAY  = 3'd4;

  // Error codes.
  localparam logic [3:0] ERR_DEPTH    = 4'd0;
  localparam logic [3:0] ERR_EOD      = 4'd1;
  localparam logic [3:0] ERR_TYPE     = 4'd2;
  localparam logic [3:0] ERR_NUMBER   = 4'd3;
  localparam logic [3:0] ERR_RANGE    = 4'd4;
  localparam logic [3:0] ERR_BULK_LEN = 4'd5;
  localparam logic [3:0] ERR_BOUNDARY = 4'd6;
  localparam logic [3:0] ERR_CRLF     = 4'd7;
  localparam logic [3:0] ERR_COUNT    = 4'd8;

  // One result beat.
  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         etype;
    logic signed [63:0] value;
    logic [7:0]         pbyte;
    logic [DEPTH_W-1:0] level;
    logic               done;
    logic [3:0]         err;
    logic               last;
  } rsp_event_t;

  // Configuration registers as seen by the parser core.
  typedef struct packed {
    logic [31:0] max_bulk;
    logic [31:0] max_array;
  } rsp_cfg_t;

endpackage

// File: rtl/rsp_stream_ifs.sv
// ----------------------------------------------------------------------------
// rsp_stream_ifs: valid/ready channels of the RESP2 stream parser
// The byte input channel and the event output channel.
// ----------------------------------------------------------------------------
interface rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;

  modport source (output valid, output data_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

interface rsp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic [2:0]         element_type;
  logic signed [63:0] element_value;
  logic [7:0]         payload_byte;
  logic [5:0]         nesting_level;
  logic               frame_done;
  logic [3:0]         error_code;
  logic               last_result;

  modport source (output valid, output event_kind, output element_type,
                  output element_value, output payload_byte, output nesting_level,
                  output frame_done, output error_code, output last_result,
                  input ready);
  modport sink   (input valid, input event_kind, input element_type,
                  input element_value, input payload_byte, input nesting_level,
                  input frame_done, input error_code, input last_result,
                  output ready);
endinterface

// File: rtl/resp_stream_parser.sv
// ----------------------------------------------------------------------------
// resp_stream_parser: RESP2 byte stream parser
// Parses a RESP2 byte stream into element headers, payload bytes, string
// ends and errors.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one stream byte per beat with end_of_buffer marking the
//   last byte currently available. out_ch carries one event per beat; a byte
//   causes zero, one or two events, and last_result marks the final event of
//   a byte. cfg_we/cfg_index/cfg_wdata write the bulk length limit (index 0)
//   and the array count limit (index 1) while the parser is idle.
//   An accepted byte passes the input register and the parse step and is
//   written into the result queue before its first event is offered.
//   Throughput: one byte per cycle, set by the single parse step between the
//   input register and the four-entry result queue; a byte is taken into the
//   step only when the queue has room for two events, so bytes that cause
//   two events and a stalled receiver hold off the input.
//   When out_ch stalls, events wait in the queue and in_ch.ready drops once
//   the input register holds a byte that cannot advance.
//   Reset (rst_n low, synchronous) empties the queue, returns the parser to
//   idle and loads the register defaults. The nesting stack needs no clearing.
// ----------------------------------------------------------------------------
module resp_stream_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  rsp_in_if.sink                         in_ch,
  rsp_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata
);

  logic                in_v_r;
  logic [7:0]          in_byte_r;
  logic                in_eob_r;
  logic                adv;
  logic                room2;
  logic                push0, push1;
  rsp_pkg::rsp_event_t ev0, ev1, dout;
  rsp_pkg::rsp_cfg_t   cfg_r;

  // Input register: refills as soon as its byte moves into the parse step.
  assign adv         = in_v_r && room2;
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (adv) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.data_byte;
      in_eob_r  <= in_ch.end_of_buffer;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_bulk  <= rsp_pkg::MAX_BULK_RESET;
      cfg_r.max_array <= rsp_pkg::MAX_ARRAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsp_pkg::REG_MAX_BULK:  cfg_r.max_bulk  <= cfg_wdata;
        rsp_pkg::REG_MAX_ARRAY: cfg_r.max_array <= cfg_wdata;
      endcase
    end
  end

  rsp_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .in_byte (in_byte_r),
    .in_eob  (in_eob_r),
    .cfg     (cfg_r),
    .push0   (push0),
    .push1   (push1),
    .ev0     (ev0),
    .ev1     (ev1)
  );

  rsp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .din0      (ev0),
    .din1      (ev1),
    .room2     (room2),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dout      (dout)
  );

  // Result beat fields.
  assign out_ch.event_kind    = dout.kind;
  assign out_ch.element_type  = dout.etype;
  assign out_ch.element_value = dout.value;
  assign out_ch.payload_byte  = dout.pbyte;
  assign out_ch.nesting_level = dout.level;
  assign out_ch.frame_done    = dout.done;
  assign out_ch.error_code    = dout.err;
  assign out_ch.last_result   = dout.last;

endmodule

// File: rtl/rsp_core.sv
// ----------------------------------------------------------------------------
// rsp_core: per-byte RESP2 parse step
// Holds the parse state and the nesting stack and turns one registered byte
// into at most two events per cycle.
// ----------------------------------------------------------------------------
module rsp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          in_byte,
  input  logic                in_eob,
  input  rsp_pkg::rsp_cfg_t   cfg,
  output logic                push0,
  output logic                push1,
  output rsp_pkg::rsp_event_t ev0,
  output rsp_pkg::rsp_event_t ev1
);

  localparam int DW = rsp_pkg::DEPTH_W;
  localparam int AW = rsp_pkg::STK_AW;
  localparam int MN = rsp_pkg::MAX_NESTING;

  // Control state.
  logic [2:0]    phase_r, phase_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic          held_r, held_nxt;
  logic          hold_r, hold_nxt;
  logic          reload_r, reload_nxt;

  // Payload state.
  logic [2:0]    kind_r, kind_nxt;
  logic [63:0]   acc_r, acc_nxt;
  logic          neg_r, neg_nxt;
  logic          dig_r, dig_nxt;
  logic          ovf_r, ovf_nxt;
  logic [31:0]   left_r, left_nxt;
  logic [31:0]   top_r, top_nxt;

  // Nesting stack: counts of the levels below the top one, plus a flag per
  // level telling whether that count is above one.
  logic [31:0]   stk_mem [MN];
  logic [MN-1:0] gt1_r;
  logic [31:0]   rd_q;
  logic [31:0]   top_eff;
  logic          top_gt1;
  logic          stk_we;
  logic [AW-1:0] stk_waddr;

  // Finish: what closing the current element does to the stack.
  logic          fin_done;
  logic [DW-1:0] fin_depth;
  logic          fin_reload;
  logic [AW-1:0] fin_addr;
  logic          do_finish;
  logic          do_push;

  // Step scratch.
  logic [1:0]    n_res;
  logic          perr;
  logic [3:0]    pcode;
  logic          err_all;
  logic [3:0]    err_code;
  logic [2:0]    ph_a;
  logic          dig_add;
  logic          is_digit;
  logic          is_ws;
  logic [67:0]   acc_x10;
  logic [67:0]   limit_x;
  logic [63:0]   num_val;
  logic          is_null;
  logic          is_neg;
  rsp_pkg::rsp_event_t ev_a, ev_b;

  function automatic rsp_pkg::rsp_event_t mk_ev(input logic [1:0] kind,
                                                input logic [2:0] et,
                                                input logic [63:0] val,
                                                input logic [7:0] pb,
                                                input logic [DW-1:0] lvl,
                                                input logic done);
    rsp_pkg::rsp_event_t e;
    e       = '0;
    e.kind  = kind;
    e.etype = et;
    e.value = val;
    e.pbyte = pb;
    e.level = lvl;
    e.done  = done;
    return e;
  endfunction

  // Top count, with a pending reload from the stack folded in.
  assign top_eff = reload_r ? (rd_q - 32'd1) : top_r;
  assign top_gt1 = top_eff > 32'd1;

  // Closing an element: pop exhausted levels, decrement the first live one.
  always_comb begin
    fin_done   = 1'b0;
    fin_depth  = depth_r;
    fin_reload = 1'b0;
    fin_addr   = '0;
    if (depth_r == '0) begin
      fin_done = 1'b1;
    end else if (!top_gt1) begin
      fin_depth = '0;
      fin_done  = 1'b1;
      for (int i = 0; i < MN; i++) begin
        if ((i + 1) < int'(depth_r) && gt1_r[i]) begin
          fin_done   = 1'b0;
          fin_reload = 1'b1;
          fin_addr   = AW'(i);
          fin_depth  = DW'(i + 1);
        end
      end
    end
  end

  // Character classes and the decimal accumulate.
  assign is_digit = (in_byte >= rsp_pkg::CH_ZERO) && (in_byte <= rsp_pkg::CH_NINE);
  assign is_ws    = (in_byte == rsp_pkg::CH_SPACE) ||
                    ((in_byte >= rsp_pkg::CH_TAB) && (in_byte <= rsp_pkg::CH_CR));
  assign acc_x10  = ({4'd0, acc_r} << 3) + ({4'd0, acc_r} << 1) + {64'd0, in_byte[3:0]};
  assign limit_x  = neg_r ? 68'h0_8000_0000_0000_0000 : 68'h0_7FFF_FFFF_FFFF_FFFF;
  assign num_val  = neg_r ? (64'd0 - acc_r) : acc_r;
  assign is_null  = neg_r && (acc_r == 64'd1);
  assign is_neg   = neg_r && (acc_r != 64'd0);

  // Main step.
  always_comb begin
    phase_nxt  = phase_r;
    depth_nxt  = depth_r;
    held_nxt   = held_r;
    hold_nxt   = hold_r;
    reload_nxt = 1'b0;
    kind_nxt   = kind_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    dig_nxt    = dig_r;
    ovf_nxt    = ovf_r;
    left_nxt   = left_r;
    top_nxt    = top_eff;
    n_res      = 2'd0;
    perr       = 1'b0;
    pcode      = rsp_pkg::ERR_DEPTH;
    ev_a       = '0;
    ev_b       = '0;
    do_finish  = 1'b0;
    do_push    = 1'b0;
    ph_a       = phase_r;
    dig_add    = 1'b0;
    err_all    = 1'b0;
    err_code   = rsp_pkg::ERR_DEPTH;

    unique case (phase_r)
      rsp_pkg::PH_IDLE: begin
        if (in_byte == rsp_pkg::CH_PLUS || in_byte == rsp_pkg::CH_MINUS) begin
          kind_nxt  = (in_byte == rsp_pkg::CH_PLUS) ? rsp_pkg::TY_SIMPLE : rsp_pkg::TY_ERROR;
          ev_a      = mk_ev(rsp_pkg::EV_HEADER, kind_nxt, 64'd0, 8'd0, depth_r, 1'b0);
          n_res     = 2'd1;
          held_nxt  = 1'b0;
          phase_nxt = rsp_pkg::PH_LINE;
        end else if (in_byte == rsp_pkg::CH_COLON || in_byte == rsp_pkg::CH_DOLLAR ||
                     in_byte == rsp_pkg::CH_STAR) begin
          kind_nxt  = (in_byte == rsp_pkg::CH_COLON)  ? rsp_pkg::TY_INT :
                      (in_byte == rsp_pkg::CH_DOLLAR) ? rsp_pkg::TY_BULK : rsp_pkg::TY_ARRAY;
          acc_nxt   = 64'd0;
          neg_nxt   = 1'b0;
          dig_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
          held_nxt  = 1'b0;
          phase_nxt = rsp_pkg::PH_NUM_LEAD;
        end else begin
          perr  = 1'b1;
          pcode = rsp_pkg::ERR_TYPE;
        end
      end

      rsp_pkg::PH_LINE: begin
        if (held_r && in_byte == rsp_pkg::CH_LF) begin
          held_nxt  = 1'b0;
          do_finish = 1'b1;
          ev_a      = mk_ev(rsp_pkg::EV_END, kind_r, 64'd0, 8'd0, depth_r, fin_done);
          n_res     = 2'd1;
        end else if (held_r) begin
          // The held CR turns out to be line content.
          ev_a = mk_ev(rsp_pkg::EV_PAYLOAD, kind_r, 64'd0, rsp_pkg::CH_CR, depth_r, 1'b0);
          if (in_byte == rsp_pkg::CH_CR) begin
            held_nxt = 1'b1;
            n_res    = 2'd1;
          end else begin
            held_nxt = 1'b0;
            ev_b     = mk_ev(rsp_pkg::EV_PAYLOAD, kind_r, 64'd0, in_byte, depth_r, 1'b0);
            n_res    = 2'd2;
          end
        end else if (in_byte == rsp_pkg::CH_CR) begin
          held_nxt = 1'b1;
        end else begin
          ev_a  = mk_ev(rsp_pkg::EV_PAYLOAD, kind_r, 64'd0, in_byte, depth_r, 1'b0);
          n_res = 2'd1;
        end
      end

      rsp_pkg::PH_NUM_LEAD, rsp_pkg::PH_NUM_BODY, rsp_pkg::PH_NUM_JUNK: begin
        if (held_r && in_byte == rsp_pkg::CH_LF) begin
          // End of the number line: judge and act on it.
          held_nxt = 1'b0;
          if (ovf_r) begin
            perr  = 1'b1;
            pcode = rsp_pkg::ERR_RANGE;
          end else if (phase_r != rsp_pkg::PH_NUM_BODY || !dig_r) begin
            perr  = 1'b1;
            pcode = rsp_pkg::ERR_NUMBER;
          end else if (kind_r == rsp_pkg::TY_INT || is_null) begin
            do_finish = 1'b1;
            ev_a      = mk_ev(rsp_pkg::EV_HEADER, kind_r, num_val, 8'd0, depth_r, fin_done);
            n_res     = 2'd1;
          end else if (kind_r == rsp_pkg::TY_BULK) begin
            if (is_neg || acc_r > {32'd0, cfg.max_bulk}) begin
              perr  = 1'b1;
              pcode = rsp_pkg::ERR_BULK_LEN;
            end else begin
              ev_a      = mk_ev(rsp_pkg::EV_HEADER, rsp_pkg::TY_BULK, num_val, 8'd0,
                                depth_r, 1'b0);
              n_res     = 2'd1;
              left_nxt  = acc_r[31:0];
              phase_nxt = (acc_r == 64'd0) ? rsp_pkg::PH_BULK_CR : rsp_pkg::PH_BULK;
            end
          end else begin
            if (is_neg || acc_r > {32'd0, cfg.max_array}) begin
              perr  = 1'b1;
              pcode = rsp_pkg::ERR_COUNT;
            end else if (acc_r == 64'd0) begin
              do_finish = 1'b1;
              ev_a      = mk_ev(rsp_pkg::EV_HEADER, rsp_pkg::TY_ARRAY, 64'd0, 8'd0,
                                depth_r, fin_done);
              n_res     = 2'd1;
            end else if (depth_r >= DW'(MN)) begin
              perr  = 1'b1;
              pcode = rsp_pkg::ERR_DEPTH;
            end else begin
              ev_a      = mk_ev(rsp_pkg::EV_HEADER, rsp_pkg::TY_ARRAY, num_val, 8'd0,
                                depth_r, 1'b0);
              n_res     = 2'd1;
              do_push   = 1'b1;
              top_nxt   = acc_r[31:0];
              depth_nxt = depth_r + DW'(1);
              phase_nxt = rsp_pkg::PH_IDLE;
            end
          end
        end else begin
          // A held CR that is not followed by LF is whitespace before the
          // number and junk after it.
          if (held_r && phase_r != rsp_pkg::PH_NUM_LEAD) begin
            ph_a = rsp_pkg::PH_NUM_JUNK;
          end
          held_nxt  = (in_byte == rsp_pkg::CH_CR);
          phase_nxt = ph_a;
          if (in_byte != rsp_pkg::CH_CR) begin
            if (ph_a == rsp_pkg::PH_NUM_LEAD) begin
              if (is_ws) begin
                phase_nxt = ph_a;
              end else if (in_byte == rsp_pkg::CH_PLUS || in_byte == rsp_pkg::CH_MINUS) begin
                neg_nxt   = neg_r || (in_byte == rsp_pkg::CH_MINUS);
                phase_nxt = rsp_pkg::PH_NUM_BODY;
              end else if (is_digit) begin
                dig_add   = 1'b1;
                phase_nxt = rsp_pkg::PH_NUM_BODY;
              end else begin
                phase_nxt = rsp_pkg::PH_NUM_JUNK;
              end
            end else if (ph_a == rsp_pkg::PH_NUM_BODY) begin
              if (is_digit) begin
                dig_add = 1'b1;
              end else begin
                phase_nxt = rsp_pkg::PH_NUM_JUNK;
              end
            end
          end
          if (dig_add) begin
            dig_nxt = 1'b1;
            if (!ovf_r) begin
              if (acc_x10 > limit_x) begin
                ovf_nxt = 1'b1;
              end else begin
                acc_nxt = acc_x10[63:0];
              end
            end
          end
        end
      end

      rsp_pkg::PH_BULK: begin
        ev_a  = mk_ev(rsp_pkg::EV_PAYLOAD, rsp_pkg::TY_BULK, 64'd0, in_byte, depth_r, 1'b0);
        n_res = 2'd1;
        if (left_r <= 32'd1) begin
          left_nxt  = 32'd0;
          phase_nxt = rsp_pkg::PH_BULK_CR;
        end else begin
          left_nxt = left_r - 32'd1;
        end
      end

      rsp_pkg::PH_BULK_CR: begin
        if (in_byte != rsp_pkg::CH_CR) begin
          perr  = 1'b1;
          pcode = rsp_pkg::ERR_CRLF;
        end else begin
          phase_nxt = rsp_pkg::PH_BULK_LF;
        end
      end

      rsp_pkg::PH_BULK_LF: begin
        if (in_byte != rsp_pkg::CH_LF) begin
          perr  = 1'b1;
          pcode = rsp_pkg::ERR_CRLF;
        end else begin
          do_finish = 1'b1;
          ev_a      = mk_ev(rsp_pkg::EV_END, rsp_pkg::TY_BULK, 64'd0, 8'd0, depth_r, fin_done);
          n_res     = 2'd1;
        end
      end

      default: begin
        phase_nxt = rsp_pkg::PH_IDLE;
      end
    endcase

    // Apply the stack side of closing an element.
    if (do_finish) begin
      phase_nxt  = rsp_pkg::PH_IDLE;
      depth_nxt  = fin_depth;
      reload_nxt = fin_reload;
      if (top_gt1) begin
        top_nxt = top_eff - 32'd1;
      end
    end

    // End of buffer in the middle of a message.
    err_all  = perr;
    err_code = pcode;
    if (!perr && in_eob && !(phase_nxt == rsp_pkg::PH_IDLE && depth_nxt == '0)) begin
      err_all = 1'b1;
      if (phase_nxt == rsp_pkg::PH_IDLE) begin
        err_code = rsp_pkg::ERR_EOD;
      end else if (phase_nxt == rsp_pkg::PH_LINE || phase_nxt == rsp_pkg::PH_NUM_LEAD ||
                   phase_nxt == rsp_pkg::PH_NUM_BODY || phase_nxt == rsp_pkg::PH_NUM_JUNK) begin
        err_code = rsp_pkg::ERR_CRLF;
      end else begin
        err_code = rsp_pkg::ERR_BOUNDARY;
      end
    end
    if (err_all) begin
      ev_a       = '0;
      ev_a.kind  = rsp_pkg::EV_ERROR;
      ev_a.level = depth_nxt;
      ev_a.err   = err_code;
      n_res      = 2'd1;
    end

    // While an error is held, bytes are dropped.
    if (hold_r) begin
      n_res = 2'd0;
    end

    // An end-of-buffer byte always returns the parser to idle.
    if (in_eob) begin
      phase_nxt  = rsp_pkg::PH_IDLE;
      depth_nxt  = '0;
      held_nxt   = 1'b0;
      hold_nxt   = 1'b0;
      reload_nxt = 1'b0;
    end else if (hold_r) begin
      phase_nxt  = phase_r;
      depth_nxt  = depth_r;
      held_nxt   = held_r;
      reload_nxt = 1'b0;
    end else if (err_all) begin
      hold_nxt = 1'b1;
    end

    // Mark the last beat of this byte.
    if (n_res == 2'd2) begin
      ev_b.last = 1'b1;
    end else begin
      ev_a.last = 1'b1;
    end
  end

  assign push0     = step && (n_res != 2'd0);
  assign push1     = step && (n_res == 2'd2);
  assign ev0       = ev_a;
  assign ev1       = ev_b;
  assign stk_we    = step && !hold_r && do_push && (depth_r != '0);
  assign stk_waddr = AW'(depth_r - DW'(1));

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= rsp_pkg::PH_IDLE;
      depth_r  <= '0;
      held_r   <= 1'b0;
      hold_r   <= 1'b0;
      reload_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      depth_r  <= depth_nxt;
      held_r   <= held_nxt;
      hold_r   <= hold_nxt;
      reload_r <= reload_nxt;
    end else begin
      reload_r <= 1'b0;
    end
  end

  // Payload registers; the top count absorbs a pending reload also when no byte is stepped or an error is held.
  always_ff @(posedge clk) begin
    if (step && !hold_r) begin
      kind_r <= kind_nxt;
      acc_r  <= acc_nxt;
      neg_r  <= neg_nxt;
      dig_r  <= dig_nxt;
      ovf_r  <= ovf_nxt;
      left_r <= left_nxt;
      top_r  <= top_nxt;
    end else begin
      top_r <= top_eff;
    end
  end

  // Stack memory with registered read.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= top_eff;
      gt1_r[stk_waddr]   <= top_gt1;
    end
    if (step && do_finish && fin_reload) begin
      rd_q <= stk_mem[fin_addr];
    end
  end

endmodule

// File: rtl/rsp_out_fifo.sv
// ----------------------------------------------------------------------------
// rsp_out_fifo: result queue of the RESP2 stream parser
// Takes up to two event beats per cycle in order and hands out one beat
// per cycle, while the receiver is ready, on a valid/ready channel.
// ----------------------------------------------------------------------------
module rsp_out_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push0,
  input  logic                push1,
  input  rsp_pkg::rsp_event_t din0,
  input  rsp_pkg::rsp_event_t din1,
  output logic                room2,
  output logic                out_valid,
  input  logic                out_ready,
  output rsp_pkg::rsp_event_t dout
);

  localparam int AW = rsp_pkg::FIFO_AW;
  localparam int CW = AW + 1;

  rsp_pkg::rsp_event_t mem [rsp_pkg::FIFO_DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          pop;
  logic [CW-1:0] n_push;

  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && out_ready;
  assign room2     = (cnt_r <= CW'(rsp_pkg::FIFO_DEPTH - 2));
  assign dout      = mem[rp_r];
  assign n_push    = CW'(push0) + CW'(push1);

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(n_push);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + n_push - CW'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push0) begin
      mem[wp_r] <= din0;
    end
    if (push1) begin
      mem[wp_r + AW'(1)] <= din1;
    end
  end

endmodule
